// ===== src/cpup_pkg.sv =====
// cpup_pkg: shared constants for the complex pupil update block.
// Register indexes, update rule codes and fixed widths. No dependencies.
package cpup_pkg;

  localparam int VALUE_WIDTH_DEF = 24;   // default sample width, signed Q4.(W-4)
  localparam int REG_W           = 24;   // configuration registers, unsigned Q8.16
  localparam int CFG_IDX_W       = 2;
  localparam int DIV_W           = 62;   // divisor magnitude width

  // update_rule codes
  localparam logic [1:0] RULE_ADAPTIVE = 2'd0;
  localparam logic [1:0] RULE_CONSTANT = 2'd1;
  localparam logic [1:0] RULE_NEWTON   = 2'd2;
  localparam logic [1:0] RULE_NONE     = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RULE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SQ = 2'd3;

  localparam logic [REG_W-1:0] ONE_Q16 = 24'd65536;

endpackage

// ===== src/complex_pupil_update.sv =====
// complex_pupil_update: top level, fully pipelined complex step update.
// Depends on cpup_pkg; checker bound from cpup_checker.sv.
//
// Each item carries p, q and the current estimate (complex, signed Q4.(W-4)) and
// returns current + p*conj(q) scaled by the step weight picked by update_rule,
// saturated to W bits with saturated_flag set on a zero divisor or a clamp; the
// unused rule code passes current through. One item enters per cycle unless the
// output stalls. Stages: S0 to S2, square root (one root bit per stage, W stages),
// A1 to A5, divider (overflow check, then one quotient bit per stage, W+2 stages)
// and output. A stalled output freezes the whole pipe; nothing is lost or repeated.
// Write the registers only while no item is in flight.
module complex_pupil_update #(
  parameter int VALUE_WIDTH = cpup_pkg::VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [VALUE_WIDTH-1:0]  p_re,
  input  logic signed [VALUE_WIDTH-1:0]  p_im,
  input  logic signed [VALUE_WIDTH-1:0]  q_re,
  input  logic signed [VALUE_WIDTH-1:0]  q_im,
  input  logic signed [VALUE_WIDTH-1:0]  current_re,
  input  logic signed [VALUE_WIDTH-1:0]  current_im,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [VALUE_WIDTH-1:0]  updated_re,
  output logic signed [VALUE_WIDTH-1:0]  updated_im,
  output logic                           saturated_flag,
  input  logic                           cfg_we,
  input  logic [cpup_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpup_pkg::REG_W-1:0]     cfg_data
);
  import cpup_pkg::*;

  localparam int W   = VALUE_WIDTH;
  localparam int F   = W - 4;          // fraction bits
  localparam int ZW  = W + 5;          // signed z component
  localparam int ZMW = W + 4;          // |z|
  localparam int QW  = W + 2;          // quotient bits
  localparam int NNW = ZMW + 24;       // numerator before scaling
  localparam int NW  = NNW + 36;       // scaled numerator
  localparam int DW  = DIV_W;
  localparam logic [QW-1:0] QCAP = QW'(1) << (W + 1);
  localparam logic signed [W+3:0] VMAXX = $signed({5'b0, {(W-1){1'b1}}});
  localparam logic signed [W+3:0] VMINX = $signed({5'b11111, {(W-1){1'b0}}});

  typedef struct packed {
    logic signed [ZW-1:0] zr;
    logic signed [ZW-1:0] zi;
    logic signed [W-1:0]  cr;
    logic signed [W-1:0]  ci;
    logic [23:0]          sq;   // |p|^2 in Q16
  } sq_carry_t;

  typedef struct packed {
    logic [DW-1:0]       d;
    logic                negr;  // result sign, real
    logic                negi;
    logic                ovfr;  // quotient beyond QW bits
    logic                ovfi;
    logic                byp;   // unused rule: pass current
    logic                znr;
    logic                zni;
    logic                zzr;
    logic                zzi;
    logic signed [W-1:0] cr;
    logic signed [W-1:0] ci;
  } dv_carry_t;

  // ---------------- configuration ----------------
  logic [1:0]       update_rule;
  logic [REG_W-1:0] step_alpha;
  logic [REG_W-1:0] step_delta;
  logic [REG_W-1:0] step_alpha_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      update_rule   <= RULE_ADAPTIVE;
      step_alpha    <= ONE_Q16;
      step_delta    <= ONE_Q16;
      step_alpha_sq <= ONE_Q16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RULE:     update_rule   <= cfg_data[1:0];
        REG_ALPHA:    step_alpha    <= cfg_data;
        REG_DELTA:    step_delta    <= cfg_data;
        REG_ALPHA_SQ: step_alpha_sq <= cfg_data;
      endcase
    end
  end

  // Whole pipe advances together; the output register is the last stage.
  logic en;
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  // ---------------- S0: input register ----------------
  logic                s0_v;
  logic signed [W-1:0] s0_pr, s0_pi, s0_qr, s0_qi, s0_cr, s0_ci;

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (en) s0_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pr <= p_re;
      s0_pi <= p_im;
      s0_qr <= q_re;
      s0_qi <= q_im;
      s0_cr <= current_re;
      s0_ci <= current_im;
    end
  end

  // ---------------- S1: products ----------------
  logic                  s1_v;
  logic signed [2*W-1:0] s1_prqr, s1_piqi, s1_piqr, s1_prqi, s1_prpr, s1_pipi;
  logic signed [W-1:0]   s1_cr, s1_ci;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= s0_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prqr <= s0_pr * s0_qr;
      s1_piqi <= s0_pi * s0_qi;
      s1_piqr <= s0_pi * s0_qr;
      s1_prqi <= s0_pr * s0_qi;
      s1_prpr <= s0_pr * s0_pr;
      s1_pipi <= s0_pi * s0_pi;
      s1_cr   <= s0_cr;
      s1_ci   <= s0_ci;
    end
  end

  // ---------------- S2: z = p*conj(q), |p|^2; feeds the root pipe ----------------
  logic            sq_v   [0:W];
  logic [W-1:0]    sq_rt  [0:W];
  logic [W:0]      sq_rm  [0:W];
  logic [2*W-1:0]  sq_rad [0:W];
  sq_carry_t       sq_c   [0:W];

  logic signed [ZW-1:0] s2_zr, s2_zi;
  logic [2*W-1:0]       s2_sumsq;

  always_comb begin
    // each product floors by F before the sum
    s2_zr    = ZW'(s1_prqr >>> F) + ZW'(s1_piqi >>> F);
    s2_zi    = ZW'(s1_piqr >>> F) - ZW'(s1_prqi >>> F);
    s2_sumsq = $unsigned(s1_prpr) + $unsigned(s1_pipi);
  end

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (en) sq_v[0] <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rt[0]   <= '0;
      sq_rm[0]   <= '0;
      sq_rad[0]  <= s2_sumsq;
      sq_c[0].zr <= s2_zr;
      sq_c[0].zi <= s2_zi;
      sq_c[0].cr <= s1_cr;
      sq_c[0].ci <= s1_ci;
      sq_c[0].sq <= s2_sumsq[2*W-1 -: 24];
    end
  end

  // ---------------- root pipe: one bit of floor(sqrt) per stage ----------------
  for (genvar j = 0; j < W; j++) begin : g_sqrt
    logic [W+2:0] rm2, trial, diff;
    logic         ge;

    always_comb begin
      rm2   = {sq_rm[j], sq_rad[j][2*W-1 -: 2]};
      trial = {1'b0, sq_rt[j], 2'b01};
      diff  = rm2 - trial;
      ge    = rm2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (en) sq_v[j+1] <= sq_v[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rt[j+1]  <= {sq_rt[j][W-2:0], ge};
        sq_rm[j+1]  <= ge ? diff[W:0] : rm2[W:0];
        sq_rad[j+1] <= sq_rad[j] << 2;
        sq_c[j+1]   <= sq_c[j];
      end
    end
  end

  // ---------------- A1: mode 0 terms, |p|^4, |z| ----------------
  logic signed [24:0]    a0_dl;
  logic signed [W+25:0]  a0_prod, a0_t1;
  logic [ZW-1:0]         a0_absr, a0_absi;

  always_comb begin
    a0_dl   = 25'sd65536 - $signed({1'b0, step_delta});
    a0_prod = $signed({1'b0, sq_rt[W]}) * a0_dl;
    a0_t1   = a0_prod >>> (F - 4);
    a0_absr = sq_c[W].zr[ZW-1] ? $unsigned(-sq_c[W].zr) : $unsigned(sq_c[W].zr);
    a0_absi = sq_c[W].zi[ZW-1] ? $unsigned(-sq_c[W].zi) : $unsigned(sq_c[W].zi);
  end

  logic                a1_v;
  logic signed [33:0]  a1_t1;
  logic [35:0]         a1_t2;
  logic [47:0]         a1_sqsq;
  logic [ZMW-1:0]      a1_zmr, a1_zmi;
  logic                a1_znr, a1_zni, a1_zzr, a1_zzi;
  logic signed [W-1:0] a1_cr, a1_ci;
  logic [23:0]         a1_sq;
  logic [47:0]         a0_ad;

  assign a0_ad = 48'(step_alpha) * 48'(step_delta);

  always_ff @(posedge clk) begin
    if (rst) a1_v <= 1'b0;
    else if (en) a1_v <= sq_v[W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_t1   <= 34'(a0_t1);
      a1_t2   <= a0_ad[47:12];
      a1_sqsq <= 48'(sq_c[W].sq) * 48'(sq_c[W].sq);
      a1_zmr  <= a0_absr[ZMW-1:0];
      a1_zmi  <= a0_absi[ZMW-1:0];
      a1_znr  <= sq_c[W].zr[ZW-1];
      a1_zni  <= sq_c[W].zi[ZW-1];
      a1_zzr  <= sq_c[W].zr == '0;
      a1_zzi  <= sq_c[W].zi == '0;
      a1_cr   <= sq_c[W].cr;
      a1_ci   <= sq_c[W].ci;
      a1_sq   <= sq_c[W].sq;
    end
  end

  // ---------------- A2: weight sum, |p|^4+delta, mode 2 numerators ----------------
  logic                a2_v;
  logic signed [37:0]  a2_tsum;
  logic [31:0]         a2_ehi;
  logic [NNW-1:0]      a2_n2r, a2_n2i;
  logic [ZMW-1:0]      a2_zmr, a2_zmi;
  logic                a2_znr, a2_zni, a2_zzr, a2_zzi;
  logic signed [W-1:0] a2_cr, a2_ci;
  logic [47:0]         a1_e;

  assign a1_e = a1_sqsq + {8'b0, step_delta, 16'b0};

  always_ff @(posedge clk) begin
    if (rst) a2_v <= 1'b0;
    else if (en) a2_v <= a1_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_tsum <= {{4{a1_t1[33]}}, a1_t1} + $signed({2'b0, a1_t2});
      a2_ehi  <= a1_e[47:16];
      a2_n2r  <= NNW'(a1_zmr) * NNW'(a1_sq);
      a2_n2i  <= NNW'(a1_zmi) * NNW'(a1_sq);
      a2_zmr  <= a1_zmr;
      a2_zmi  <= a1_zmi;
      a2_znr  <= a1_znr;
      a2_zni  <= a1_zni;
      a2_zzr  <= a1_zzr;
      a2_zzi  <= a1_zzi;
      a2_cr   <= a1_cr;
      a2_ci   <= a1_ci;
    end
  end

  // ---------------- A3: divisor partial products ----------------
  logic                a3_v;
  logic [42:0]         a3_pl;
  logic signed [43:0]  a3_ph;
  logic [55:0]         a3_d2;
  logic [NNW-1:0]      a3_n2r, a3_n2i;
  logic [ZMW-1:0]      a3_zmr, a3_zmi;
  logic                a3_znr, a3_zni, a3_zzr, a3_zzi;
  logic signed [W-1:0] a3_cr, a3_ci;

  always_ff @(posedge clk) begin
    if (rst) a3_v <= 1'b0;
    else if (en) a3_v <= a2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3_pl  <= 43'(a2_tsum[18:0]) * 43'(step_alpha);
      a3_ph  <= $signed(a2_tsum[37:19]) * $signed({1'b0, step_alpha});
      a3_d2  <= 56'(a2_ehi) * 56'(step_alpha);
      a3_n2r <= a2_n2r;
      a3_n2i <= a2_n2i;
      a3_zmr <= a2_zmr;
      a3_zmi <= a2_zmi;
      a3_znr <= a2_znr;
      a3_zni <= a2_zni;
      a3_zzr <= a2_zzr;
      a3_zzi <= a2_zzi;
      a3_cr  <= a2_cr;
      a3_ci  <= a2_ci;
    end
  end

  // ---------------- A4: mode 0 weight w = (t1+t2)*alpha ----------------
  logic                a4_v;
  logic signed [62:0]  a4_w;
  logic [55:0]         a4_d2;
  logic [NNW-1:0]      a4_n2r, a4_n2i;
  logic [ZMW-1:0]      a4_zmr, a4_zmi;
  logic                a4_znr, a4_zni, a4_zzr, a4_zzi;
  logic signed [W-1:0] a4_cr, a4_ci;

  always_ff @(posedge clk) begin
    if (rst) a4_v <= 1'b0;
    else if (en) a4_v <= a3_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4_w   <= $signed({a3_ph, 19'b0}) + $signed({20'b0, a3_pl});
      a4_d2  <= a3_d2;
      a4_n2r <= a3_n2r;
      a4_n2i <= a3_n2i;
      a4_zmr <= a3_zmr;
      a4_zmi <= a3_zmi;
      a4_znr <= a3_znr;
      a4_zni <= a3_zni;
      a4_zzr <= a3_zzr;
      a4_zzi <= a3_zzi;
      a4_cr  <= a3_cr;
      a4_ci  <= a3_ci;
    end
  end

  // ---------------- A5: pick divisor and numerators by rule ----------------
  logic           a4_negd, a4_byp, a4_s36;
  logic [DW-1:0]  a4_dsel;
  logic [NNW-1:0] a4_nr, a4_ni;

  always_comb begin
    a4_negd = 1'b0;
    a4_byp  = 1'b0;
    a4_s36  = 1'b0;
    a4_dsel = '0;
    a4_nr   = NNW'(a4_zmr);
    a4_ni   = NNW'(a4_zmi);
    unique case (update_rule)
      RULE_ADAPTIVE: begin
        a4_negd = a4_w[62];
        a4_dsel = a4_w[62] ? DW'(-a4_w) : DW'(a4_w);
        a4_s36  = 1'b1;
      end
      RULE_CONSTANT: begin
        a4_dsel = DW'(step_alpha_sq);
      end
      RULE_NEWTON: begin
        a4_dsel = DW'(a4_d2);
        a4_nr   = a4_n2r;
        a4_ni   = a4_n2i;
      end
      default: begin
        a4_byp = 1'b1;
      end
    endcase
  end

  logic                a5_v;
  logic [DW-1:0]       a5_d;
  logic                a5_negd, a5_byp;
  logic [NW-1:0]       a5_nr, a5_ni;
  logic                a5_znr, a5_zni, a5_zzr, a5_zzi;
  logic signed [W-1:0] a5_cr, a5_ci;

  always_ff @(posedge clk) begin
    if (rst) a5_v <= 1'b0;
    else if (en) a5_v <= a4_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a5_d    <= a4_dsel;
      a5_negd <= a4_negd;
      a5_byp  <= a4_byp;
      a5_nr   <= a4_s36 ? {a4_nr, 36'b0} : {20'b0, a4_nr, 16'b0};
      a5_ni   <= a4_s36 ? {a4_ni, 36'b0} : {20'b0, a4_ni, 16'b0};
      a5_znr  <= a4_znr;
      a5_zni  <= a4_zni;
      a5_zzr  <= a4_zzr;
      a5_zzi  <= a4_zzi;
      a5_cr   <= a4_cr;
      a5_ci   <= a4_ci;
    end
  end

  // ---------------- divider: overflow check, then one quotient bit per stage ----------------
  logic          dv_v    [0:QW];
  logic [DW-1:0] dv_remr [0:QW];
  logic [DW-1:0] dv_remi [0:QW];
  logic [QW-1:0] dv_lor  [0:QW];
  logic [QW-1:0] dv_loi  [0:QW];
  logic [QW-1:0] dv_qr   [0:QW];
  logic [QW-1:0] dv_qi   [0:QW];
  dv_carry_t     dv_c    [0:QW];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (en) dv_v[0] <= a5_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_remr[0]   <= a5_nr[NW-1:QW];
      dv_remi[0]   <= a5_ni[NW-1:QW];
      dv_lor[0]    <= a5_nr[QW-1:0];
      dv_loi[0]    <= a5_ni[QW-1:0];
      dv_qr[0]     <= '0;
      dv_qi[0]     <= '0;
      dv_c[0].d    <= a5_d;
      dv_c[0].negr <= a5_znr ^ a5_negd;
      dv_c[0].negi <= a5_zni ^ a5_negd;
      dv_c[0].ovfr <= a5_nr[NW-1:QW] >= a5_d;
      dv_c[0].ovfi <= a5_ni[NW-1:QW] >= a5_d;
      dv_c[0].byp  <= a5_byp;
      dv_c[0].znr  <= a5_znr;
      dv_c[0].zni  <= a5_zni;
      dv_c[0].zzr  <= a5_zzr;
      dv_c[0].zzi  <= a5_zzi;
      dv_c[0].cr   <= a5_cr;
      dv_c[0].ci   <= a5_ci;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW:0] r2r, r2i, dfr, dfi;
    logic        ger, gei;

    always_comb begin
      r2r = {dv_remr[k], dv_lor[k][QW-1]};
      r2i = {dv_remi[k], dv_loi[k][QW-1]};
      dfr = r2r - {1'b0, dv_c[k].d};
      dfi = r2i - {1'b0, dv_c[k].d};
      ger = r2r >= {1'b0, dv_c[k].d};
      gei = r2i >= {1'b0, dv_c[k].d};
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k+1] <= 1'b0;
      else if (en) dv_v[k+1] <= dv_v[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_remr[k+1] <= ger ? dfr[DW-1:0] : r2r[DW-1:0];
        dv_remi[k+1] <= gei ? dfi[DW-1:0] : r2i[DW-1:0];
        dv_lor[k+1]  <= dv_lor[k] << 1;
        dv_loi[k+1]  <= dv_loi[k] << 1;
        dv_qr[k+1]   <= {dv_qr[k][QW-2:0], ger};
        dv_qi[k+1]   <= {dv_qi[k][QW-2:0], gei};
        dv_c[k+1]    <= dv_c[k];
      end
    end
  end

  // ---------------- output: cap, sign, add, clamp ----------------
  // Returns {sat, value}.
  function automatic logic [W:0] finish(input logic [QW-1:0] q, input logic ovf,
                                        input logic neg, input logic dz,
                                        input logic zn, input logic zz,
                                        input logic signed [W-1:0] cur);
    logic [QW-1:0]     qm;
    logic signed [QW:0] t;
    logic signed [W+3:0] sum;
    logic [W:0]        r;
    qm  = (ovf || q > QCAP) ? QCAP : q;
    t   = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
    sum = $signed({{4{cur[W-1]}}, cur}) + $signed({t[QW], t});
    if (dz) begin
      // zero divisor: push toward the sign of z, hold on zero
      if (zn)      r = {1'b1, VMINX[W-1:0]};
      else if (zz) r = {1'b1, cur};
      else         r = {1'b1, VMAXX[W-1:0]};
    end else if (sum > VMAXX) begin
      r = {1'b1, VMAXX[W-1:0]};
    end else if (sum < VMINX) begin
      r = {1'b1, VMINX[W-1:0]};
    end else begin
      r = {1'b0, sum[W-1:0]};
    end
    return r;
  endfunction

  logic       f_dz;
  logic [W:0] f_re, f_im;

  always_comb begin
    f_dz = dv_c[QW].d == '0;
    f_re = finish(dv_qr[QW], dv_c[QW].ovfr, dv_c[QW].negr, f_dz,
                  dv_c[QW].znr, dv_c[QW].zzr, dv_c[QW].cr);
    f_im = finish(dv_qi[QW], dv_c[QW].ovfi, dv_c[QW].negi, f_dz,
                  dv_c[QW].zni, dv_c[QW].zzi, dv_c[QW].ci);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_v[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dv_c[QW].byp) begin
        updated_re     <= dv_c[QW].cr;
        updated_im     <= dv_c[QW].ci;
        saturated_flag <= 1'b0;
      end else begin
        updated_re     <= $signed(f_re[W-1:0]);
        updated_im     <= $signed(f_im[W-1:0]);
        saturated_flag <= f_re[W] | f_im[W];
      end
    end
  end

endmodule

// ===== src/cpup_checker.sv =====
// cpup_checker: port-level assertions for complex_pupil_update, with its bind.
// Depends on cpup_pkg for port widths.
module cpup_checker #(
  parameter int VALUE_WIDTH = cpup_pkg::VALUE_WIDTH_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic signed [VALUE_WIDTH-1:0]  p_re,
  input logic signed [VALUE_WIDTH-1:0]  p_im,
  input logic signed [VALUE_WIDTH-1:0]  q_re,
  input logic signed [VALUE_WIDTH-1:0]  q_im,
  input logic signed [VALUE_WIDTH-1:0]  current_re,
  input logic signed [VALUE_WIDTH-1:0]  current_im,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [VALUE_WIDTH-1:0]  updated_re,
  input logic signed [VALUE_WIDTH-1:0]  updated_im,
  input logic                           saturated_flag,
  input logic                           cfg_we,
  input logic [cpup_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [cpup_pkg::REG_W-1:0]     cfg_data
);

  // pipe comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(updated_re) &&
      $stable(updated_im) && $stable(saturated_flag))
    else $error("stalled result changed");

  // a stall at the output blocks intake
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("item taken while output stalled");

  // with the output free, intake is open
  a_free_takes: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("intake closed with output free");

endmodule

bind complex_pupil_update cpup_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_cpup_checker (.*);

// ===== verif/pupil_scoreboard.sv =====
// pupil_scoreboard: computes the expected complex pupil update for each accepted item
// and checks results in order. Depends on cpup_pkg for register indexes and rule codes.
`timescale 1ns / 1ps

class pupil_scoreboard;
  localparam int W = 24;
  localparam int FRAC = W - 4;
  localparam longint VMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint unsigned QCAP = 64'd1 << (W + 1);

  typedef struct {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic                sat;
  } update_t;

  logic [1:0]  rule = cpup_pkg::RULE_ADAPTIVE;
  logic [23:0] alpha = cpup_pkg::ONE_Q16;
  logic [23:0] delta = cpup_pkg::ONE_Q16;
  logic [23:0] alpha_sq = cpup_pkg::ONE_Q16;
  update_t     pending[$];
  int          mismatches = 0;

  function void set_reg(logic [1:0] idx, logic [23:0] v);
    case (idx)
      cpup_pkg::REG_RULE:  rule = v[1:0];
      cpup_pkg::REG_ALPHA: alpha = v;
      cpup_pkg::REG_DELTA: delta = v;
      default:             alpha_sq = v;
    endcase
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function update_t predict_update(logic signed [W-1:0] a, b, c, e, f, g);
    longint pr, pi, qr, qi, t1, t2, w, t, v;
    longint cur[2], z[2];
    longint unsigned sumsq, mult, d, m, sq, en, qm, zm;
    logic [127:0] quo;
    int s;
    bit neg_div, neg, sat;
    update_t r;
    pr = a; pi = b; qr = c; qi = e; cur[0] = f; cur[1] = g;
    z[0] = ((pr * qr) >>> FRAC) + ((pi * qi) >>> FRAC);
    z[1] = ((pi * qr) >>> FRAC) - ((pr * qi) >>> FRAC);
    sumsq = pr * pr + pi * pi;
    mult = 1; d = 0; s = 16; neg_div = 0; sat = 0;
    case (rule)
      cpup_pkg::RULE_ADAPTIVE: begin
        m = int_sqrt(sumsq);
        t1 = (longint'(m) * (64'sd65536 - longint'({40'd0, delta}))) >>> (FRAC - 4);
        t2 = longint'(({40'd0, alpha} * {40'd0, delta}) >> 12);
        w = (t1 + t2) * longint'({40'd0, alpha});
        neg_div = w < 0;
        d = neg_div ? -w : w;
        s = 36;
      end
      cpup_pkg::RULE_CONSTANT: d = {40'd0, alpha_sq};
      cpup_pkg::RULE_NEWTON: begin
        sq = sumsq >> (2 * FRAC - 16);
        en = sq * sq + ({40'd0, delta} << 16);
        d = (en >> 16) * {40'd0, alpha};
        mult = sq;
      end
      default: begin
        // unused selector passes the estimate through untouched
        r.re = f; r.im = g; r.sat = 0;
        return r;
      end
    endcase
    for (int k = 0; k < 2; k++) begin
      if (d == 0) begin
        sat = 1;
        v = z[k] > 0 ? VMAX : (z[k] < 0 ? VMIN : cur[k]);
      end else begin
        zm = z[k] < 0 ? -z[k] : z[k];
        quo = ({64'd0, zm * mult} << s) / {64'd0, d};
        qm = (quo > QCAP) ? QCAP : quo[63:0];
        neg = (z[k] < 0) != neg_div;
        t = neg ? -longint'(qm) : longint'(qm);
        v = cur[k] + t;
        if (v > VMAX) begin v = VMAX; sat = 1; end
        else if (v < VMIN) begin v = VMIN; sat = 1; end
      end
      if (k == 0) r.re = v[W-1:0];
      else r.im = v[W-1:0];
    end
    r.sat = sat;
    return r;
  endfunction

  function void note_input(logic signed [W-1:0] a, b, c, e, f, g);
    pending.push_back(predict_update(a, b, c, e, f, g));
  endfunction

  function void check_result(logic signed [W-1:0] re, im, logic sat);
    update_t x;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result re=%0d im=%0d sat=%0b", re, im, sat);
      return;
    end
    x = pending.pop_front();
    if (x.re !== re || x.im !== im || x.sat !== sat) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp re=%0d im=%0d sat=%0b, got re=%0d im=%0d sat=%0b",
                 x.re, x.im, x.sat, re, im, sat);
    end
  endfunction
endclass

// ===== verif/tb_complex_pupil_update.sv =====
// tb_complex_pupil_update: drives the pupil update pipeline with directed and random
// items across register settings; depends on cpup_pkg and pupil_scoreboard.
`timescale 1ns / 1ps

module tb_complex_pupil_update;
  import cpup_pkg::*;

  localparam int W = 24;
  localparam int DRAIN = 2 * W + 20;      // pipe latency plus margin
  localparam int WATCHDOG = 3000;         // idle cycles before giving up
  localparam logic signed [W-1:0] SMAX = 24'sh7FFFFF;
  localparam logic signed [W-1:0] SMIN = 24'sh800000;
  localparam logic signed [W-1:0] ONE = 24'sh100000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_we = 0;
  logic in_ready, out_valid, saturated_flag;
  logic signed [W-1:0] p_re = 0, p_im = 0, q_re = 0, q_im = 0;
  logic signed [W-1:0] current_re = 0, current_im = 0;
  logic signed [W-1:0] updated_re, updated_im;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [REG_W-1:0] cfg_data = 0;

  pupil_scoreboard sb = new();
  bit calm = 0;        // no idling on either side
  bit hold_req = 0;    // receiver backs off for a long stretch
  int idle_cycles = 0;

  complex_pupil_update u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random ready bursts, a long hold when asked, steady ready when calm.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1;
        n = $urandom_range(1, 10);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ready <= 0;
        n = $urandom_range(1, 10);
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // Result check and watchdog on idle cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(updated_re, updated_im, saturated_flag);
      if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic signed [W-1:0] a, b, c, e, f, g);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1;
    p_re <= a; p_im <= b; q_re <= c; q_im <= e; current_re <= f; current_im <= g;
    do @(posedge clk); while (!in_ready);
    sb.note_input(a, b, c, e, f, g);
  endtask

  // Lower valid and let everything in flight come out before touching registers.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Leaves the write enable high; set_all drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic set_all(input logic [1:0] rule, input logic [REG_W-1:0] a, d, asq);
    write_reg(REG_RULE, REG_W'(rule));
    write_reg(REG_ALPHA, a);
    write_reg(REG_DELTA, d);
    write_reg(REG_ALPHA_SQ, asq);
    cfg_we <= 0;
  endtask

  function automatic logic signed [W-1:0] rand_val(input bit moderate);
    logic [W-1:0] r;
    r = W'($urandom);
    if (moderate) return $signed(r) >>> 3;   // around +-1.0, keeps results in range
    return r;
  endfunction

  function automatic logic [REG_W-1:0] pick_reg(input bit nonzero);
    case ($urandom_range(0, 4))
      0: return nonzero ? 24'd1 : 24'd0;
      1: return ONE_Q16;
      2: return 24'hFFFFFF;
      3: return REG_W'($urandom_range(1, 24'hFFFFFF));
      default: return REG_W'($urandom_range(24'h004000, 24'h040000));
    endcase
  endfunction

  task automatic random_items(input int n);
    bit mod;
    repeat (n) begin
      mod = $urandom_range(0, 3) != 0;
      send_item(rand_val(mod), rand_val(mod), rand_val(mod), rand_val(mod),
                rand_val(mod), rand_val(mod));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed, reset settings: zero, unit, extreme operands.
    send_item(0, 0, 0, 0, 0, 0);
    send_item(ONE, 0, ONE, 0, 0, 0);
    send_item(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
    send_item(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
    send_item(SMIN, SMAX, SMAX, SMIN, 0, 0);
    send_item(ONE, -ONE, -ONE, ONE, SMAX, SMIN);
    drain();
    // Zero divisor in adaptive mode: z positive, negative and zero.
    set_all(RULE_ADAPTIVE, 24'd0, ONE_Q16, ONE_Q16);
    send_item(ONE, 0, ONE, 0, 5, 7);
    send_item(ONE, 0, -ONE, 0, 5, 7);
    send_item(0, 0, ONE, ONE, 5, 7);
    drain();
    // Negative adaptive weight (delta above one).
    set_all(RULE_ADAPTIVE, ONE_Q16, 24'hFFFFFF, ONE_Q16);
    send_item(SMAX, 0, ONE, ONE, 0, 0);
    send_item(ONE, ONE, -ONE, ONE, 100, -100);
    drain();
    // Constant step, smallest divisor: huge quotient.
    set_all(RULE_CONSTANT, ONE_Q16, ONE_Q16, 24'd1);
    send_item(SMAX, SMAX, SMAX, SMAX, 0, 0);
    send_item(ONE, 0, 1, 0, 0, 0);
    drain();
    // Pseudo-Newton, regular and zero divisor.
    set_all(RULE_NEWTON, ONE_Q16, ONE_Q16, ONE_Q16);
    send_item(ONE, ONE, ONE, -ONE, 3, 3);
    send_item(SMIN, SMIN, SMAX, SMIN, SMAX, SMIN);
    drain();
    set_all(RULE_NEWTON, 24'd0, 24'd0, ONE_Q16);
    send_item(0, 0, ONE, ONE, 9, 9);
    send_item(ONE, 0, ONE, 0, 9, 9);
    drain();
    // Unused selector.
    set_all(RULE_NONE, ONE_Q16, ONE_Q16, ONE_Q16);
    send_item(ONE, ONE, ONE, ONE, SMIN, SMAX);
    drain();

    // Random phases, each under its own register setting; empty pipe between them.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      set_all(2'(ph % 4), pick_reg(0), pick_reg(0), pick_reg(1));
      if (ph == 3) hold_req = 1;   // fill the pipe against a stalled receiver
      random_items(90);
    end
    drain();
    // Last stretch with no idling on either side.
    calm = 1;
    set_all(RULE_ADAPTIVE, ONE_Q16, 24'h008000, ONE_Q16);
    random_items(100);
    drain();

    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
